// ===== rtl/nsf_pkg.sv =====
// ----------------------------------------------------------------------------
// nsf_pkg
// Shared types for the NMEA sentence filter: stage codes and the result record.
// ----------------------------------------------------------------------------
package nsf_pkg;

  localparam logic [7:0] CHAR_LF    = 8'd10;
  localparam logic [7:0] CHAR_CR    = 8'd13;
  localparam logic [7:0] CHAR_COMMA = 8'h2C;

  localparam logic [47:0] HEADER_RESET = 48'd71774394795812;

  typedef enum logic [7:0] {
    STAGE_HUNT0 = 8'b0000_0001,
    STAGE_HDR1  = 8'b0000_0010,
    STAGE_HDR2  = 8'b0000_0100,
    STAGE_HDR3  = 8'b0000_1000,
    STAGE_HDR4  = 8'b0001_0000,
    STAGE_HDR5  = 8'b0010_0000,
    STAGE_BODY  = 8'b0100_0000,
    STAGE_TAIL  = 8'b1000_0000
  } stage_t;

  typedef struct packed {
    logic       done_bank;
    logic       sentence_done;
    logic [6:0] comma_position;
    logic [4:0] comma_slot;
    logic       comma_valid;
    logic [7:0] store_byte;
    logic [6:0] store_address;
    logic       store_bank;
    logic       store_valid;
  } result_t;

endpackage

// ===== rtl/nmea_sentence_filter_top.sv =====
// ----------------------------------------------------------------------------
// nmea_sentence_filter_top
// Path: a byte transferred in is held in the input register, then loaded into
// the result register once that is free, and transfers out from there.
// Throughput: one byte per cycle while m_tready keeps the output open; the
// header compare and index update are one short step between the two registers.
// Reset: synchronous rst returns to header byte 0 hunt, index, comma count
// and bank at zero, header pattern to "$GNGGA"; both registers empty.
// ----------------------------------------------------------------------------
module nmea_sentence_filter_top import nsf_pkg::*; #(
  parameter int LINE_BUFFER_BYTES = 128,
  parameter int COMMA_SLOTS       = 20
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // rx_byte
  output logic        m_tvalid,
  input  logic        m_tready,
  // store_valid, store_bank, store_address[6:0], store_byte[7:0], comma_valid,
  // comma_slot[4:0], comma_position[6:0], done_bank, zero pad
  output logic [31:0] m_tdata,
  output logic        m_tlast,   // sentence_done
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [47:0] cfg_data   // header_pattern
);

  localparam int IdxW = $clog2(LINE_BUFFER_BYTES + 1);
  localparam int CcW  = $clog2(COMMA_SLOTS + 1);

  logic [47:0]     header_pattern;
  stage_t          stage;
  stage_t          stage_next;
  logic [IdxW-1:0] write_index;
  logic [IdxW-1:0] write_index_next;
  logic [CcW-1:0]  comma_count;
  logic [CcW-1:0]  comma_count_next;
  logic            active_bank;
  logic            active_bank_next;
  logic            in_valid;
  logic [7:0]      in_byte;
  logic            out_valid;
  result_t         out_result;
  result_t         step_result;
  logic            out_open;
  logic            advance;

  assign cfg_ready = 1'b1;
  assign out_open  = ~out_valid | m_tready;
  assign advance   = in_valid & out_open;
  assign s_tready  = ~in_valid | advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      header_pattern <= HEADER_RESET;
    end else if (cfg_valid) begin
      header_pattern <= cfg_data;
    end
  end

  nsf_step #(
    .LINE_BUFFER_BYTES (LINE_BUFFER_BYTES),
    .COMMA_SLOTS       (COMMA_SLOTS)
  ) u_step (
    .stage            (stage),
    .write_index      (write_index),
    .comma_count      (comma_count),
    .active_bank      (active_bank),
    .header_pattern   (header_pattern),
    .rx_byte          (in_byte),
    .stage_next       (stage_next),
    .write_index_next (write_index_next),
    .comma_count_next (comma_count_next),
    .active_bank_next (active_bank_next),
    .result           (step_result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid    <= 1'b0;
      out_valid   <= 1'b0;
      stage       <= STAGE_HUNT0;
      write_index <= '0;
      comma_count <= '0;
      active_bank <= 1'b0;
    end else begin
      if (s_tvalid && s_tready) begin
        in_valid <= 1'b1;
      end else if (advance) begin
        in_valid <= 1'b0;
      end
      if (advance) begin
        out_valid   <= 1'b1;
        stage       <= stage_next;
        write_index <= write_index_next;
        comma_count <= comma_count_next;
        active_bank <= active_bank_next;
      end else if (m_tready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_byte <= s_tdata;
    end
    if (advance) begin
      out_result <= step_result;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tlast  = out_result.sentence_done;
  assign m_tdata  = {1'b0,
                     out_result.done_bank,
                     out_result.comma_position,
                     out_result.comma_slot,
                     out_result.comma_valid,
                     out_result.store_byte,
                     out_result.store_address,
                     out_result.store_bank,
                     out_result.store_valid};

endmodule

// ===== rtl/nsf_step.sv =====
// ----------------------------------------------------------------------------
// nsf_step
// Next state and result for one received byte: header hunt, body copy,
// comma slot recording, terminators and bank swap.
// ----------------------------------------------------------------------------
module nsf_step import nsf_pkg::*; #(
  parameter int LINE_BUFFER_BYTES = 128,
  parameter int COMMA_SLOTS       = 20,
  localparam int IdxW = $clog2(LINE_BUFFER_BYTES + 1),
  localparam int CcW  = $clog2(COMMA_SLOTS + 1)
) (
  input  stage_t          stage,
  input  logic [IdxW-1:0] write_index,
  input  logic [CcW-1:0]  comma_count,
  input  logic            active_bank,
  input  logic [47:0]     header_pattern,
  input  logic [7:0]      rx_byte,
  output stage_t          stage_next,
  output logic [IdxW-1:0] write_index_next,
  output logic [CcW-1:0]  comma_count_next,
  output logic            active_bank_next,
  output result_t         result
);

  localparam logic [IdxW-1:0] IdxLimit = IdxW'(LINE_BUFFER_BYTES);
  localparam logic [CcW-1:0]  CcLimit  = CcW'(COMMA_SLOTS);

  stage_t          eff_stage;
  logic [IdxW-1:0] eff_index;
  logic [7:0]      hdr_byte;
  logic [31:0]     index_wide;
  logic [31:0]     count_wide;
  logic            store;
  logic            done;

  always_comb begin
    if (write_index >= IdxLimit) begin
      eff_stage = STAGE_HUNT0;
      eff_index = '0;
    end else begin
      eff_stage = stage;
      eff_index = write_index;
    end
  end

  always_comb begin
    unique case (eff_stage)
      STAGE_HDR1: hdr_byte = header_pattern[15:8];
      STAGE_HDR3: hdr_byte = header_pattern[31:24];
      STAGE_HDR4: hdr_byte = header_pattern[39:32];
      STAGE_HDR5: hdr_byte = header_pattern[47:40];
      default:    hdr_byte = header_pattern[7:0];
    endcase
  end

  assign index_wide = 32'(eff_index);
  assign count_wide = 32'(comma_count);

  always_comb begin
    stage_next       = eff_stage;
    write_index_next = eff_index;
    comma_count_next = comma_count;
    active_bank_next = active_bank;
    result           = '0;
    store            = 1'b0;
    done             = 1'b0;

    unique case (eff_stage) inside
      STAGE_HUNT0: begin
        if (rx_byte == hdr_byte) begin
          comma_count_next  = '0;
          store             = 1'b1;
          result.store_byte = rx_byte;
          stage_next        = STAGE_HDR1;
        end else begin
          write_index_next = '0;
        end
      end
      STAGE_HDR2: begin
        store             = 1'b1;
        result.store_byte = rx_byte;
        stage_next        = STAGE_HDR3;
      end
      STAGE_HDR1, STAGE_HDR3, STAGE_HDR4, STAGE_HDR5: begin
        if (rx_byte == hdr_byte) begin
          store             = 1'b1;
          result.store_byte = rx_byte;
          unique case (eff_stage)
            STAGE_HDR1: stage_next = STAGE_HDR2;
            STAGE_HDR3: stage_next = STAGE_HDR4;
            STAGE_HDR4: stage_next = STAGE_HDR5;
            default:    stage_next = STAGE_BODY;
          endcase
        end else begin
          write_index_next = '0;
          stage_next       = STAGE_HUNT0;
        end
      end
      STAGE_BODY: begin
        store = 1'b1;
        if (rx_byte == CHAR_LF || rx_byte == CHAR_CR) begin
          result.store_byte = '0;
          stage_next        = STAGE_TAIL;
        end else begin
          result.store_byte = rx_byte;
          if (rx_byte == CHAR_COMMA && comma_count < CcLimit) begin
            result.comma_valid    = 1'b1;
            result.comma_slot     = count_wide[4:0];
            result.comma_position = index_wide[6:0];
            comma_count_next      = comma_count + 1'b1;
          end
        end
      end
      STAGE_TAIL: begin
        store             = 1'b1;
        result.store_byte = '0;
        done              = 1'b1;
      end
      default: begin
        write_index_next = '0;
        stage_next       = STAGE_HUNT0;
      end
    endcase

    if (store) begin
      result.store_valid   = 1'b1;
      result.store_bank    = active_bank;
      result.store_address = index_wide[6:0];
      write_index_next     = eff_index + 1'b1;
    end
    if (done) begin
      result.sentence_done = 1'b1;
      result.done_bank     = active_bank;
      write_index_next     = '0;
      active_bank_next     = ~active_bank;
      stage_next           = STAGE_HUNT0;
    end
  end

endmodule
